/* hdl/sss_pkg.sv */
`timescale 1ns / 1ps
// Package for the sorted sequence store: sizes, request and status codes,
// transfer payload structs and the control struct broadcast to the cells.
// No dependencies.
package sss_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_CLEAR     = 3'd0,
    REQ_APPEND    = 3'd1,
    REQ_INSERT_AT = 3'd2,
    REQ_SORTED    = 3'd3,
    REQ_SEARCH    = 3'd4,
    REQ_FRONT     = 3'd5,
    REQ_READ      = 3'd6,
    REQ_NOP       = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // what marks a cell as a hit
  typedef enum logic [1:0] {
    HIT_POS   = 2'd0,
    HIT_ORDER = 2'd1,
    HIT_MATCH = 2'd2
  } hit_sel_t;

  // how the row is rewritten on a committed request
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_INSERT = 2'd1,
    WR_FRONT  = 2'd2
  } wr_kind_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] operand_value;
    logic [4:0]         target_position;
  } sss_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         found_position;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } sss_out_t;

  typedef struct packed {
    hit_sel_t           hit_sel;
    wr_kind_t           wr_kind;
    logic [CNT_W-1:0]   count;
    logic [IDX_W-1:0]   pos;
    logic signed [31:0] key;
  } sss_ctl_t;

endpackage

/* hdl/sss_cell.sv */
`timescale 1ns / 1ps
// One slot of the store: holds an entry, compares it with the broadcast key
// and takes its own or its left neighbor's value. Depends on sss_pkg.
module sss_cell (
  input  logic                      clk,
  input  sss_pkg::sss_ctl_t         ctl,
  input  logic [sss_pkg::IDX_W-1:0] idx,
  input  logic signed [31:0]        prev_val,
  input  logic                      hit_in,
  output logic                      hit_out,
  output logic [sss_pkg::IDX_W-1:0] pos_out,
  output logic signed [31:0]        val_out
);
  import sss_pkg::*;

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;
  logic               occ;
  logic               hit;
  logic               first;

  assign occ = CNT_W'(idx) < ctl.count;

  always_comb begin
    case (ctl.hit_sel)
      HIT_POS:   hit = (idx == ctl.pos);
      // first slot not holding a smaller entry; empty slots qualify
      HIT_ORDER: hit = !(occ && (entry_r < ctl.key));
      HIT_MATCH: hit = occ && (entry_r == ctl.key);
      default:   hit = 1'b0;
    endcase
  end

  assign first   = hit && !hit_in;
  assign hit_out = hit || hit_in;
  assign pos_out = first ? idx : '0;
  assign val_out = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.wr_kind)
      WR_INSERT: begin
        if (first) begin
          entry_nxt = ctl.key;
        end else if (hit_in) begin
          entry_nxt = prev_val;
        end
      end
      WR_FRONT: begin
        // head takes the key (equal to the match); slots up to the match shift
        if (idx == '0) begin
          entry_nxt = ctl.key;
        end else if (!hit_in) begin
          entry_nxt = prev_val;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* hdl/sorted_sequence_store.sv */
`timescale 1ns / 1ps
// Sorted sequence store top level: a row of sss_cell slots plus the count,
// request decode and the result register. Depends on sss_pkg and sss_cell.
//
// The store takes one request per clock unless a waiting result is stalled,
// and presents its result in the cycle after the input transfer, from a
// result register; a new request is taken in the same cycle a waiting
// result is taken. All slots compare against the key in parallel, and the
// first-hit flag that ripples through the row of slots (STORE_DEPTH cells)
// sets the position, the slots to shift and the clock period. Only slots
// below the count are ever read, and each of them was written; a read at or
// past the count returns bad position. Slot contents have no reset; the count
// resets to 0.
module sorted_sequence_store (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sss_pkg::sss_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sss_pkg::sss_out_t out_data
);
  import sss_pkg::*;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  sss_out_t           out_data_r;
  sss_out_t           res;
  sss_ctl_t           ctl;
  logic               accept;
  logic               full;
  logic               found_any;
  logic [IDX_W-1:0]   chain_pos;
  logic [IDX_W-1:0]   rd_idx;
  logic [31:0]        pos_w;
  logic [31:0]        cnt_w;
  logic               hit_c [STORE_DEPTH+1];
  logic [IDX_W-1:0]   pos_c [STORE_DEPTH];
  logic signed [31:0] val_c [STORE_DEPTH];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign full   = (count_r == CNT_W'(STORE_DEPTH));
  assign pos_w  = 32'(in_data.target_position);
  assign cnt_w  = 32'(count_r);
  assign rd_idx = IDX_W'(in_data.target_position);

  // ---- slot row ----
  assign hit_c[0] = 1'b0;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    sss_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (IDX_W'(i)),
      .prev_val ((i == 0) ? ctl.key : val_c[(i == 0) ? 0 : i-1]),
      .hit_in   (hit_c[i]),
      .hit_out  (hit_c[i+1]),
      .pos_out  (pos_c[i]),
      .val_out  (val_c[i])
    );
  end

  assign found_any = hit_c[STORE_DEPTH];

  always_comb begin
    chain_pos = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      chain_pos = chain_pos | pos_c[i];
    end
  end

  // ---- request decode ----
  always_comb begin
    res                = '0;
    res.status         = ST_OK;
    count_nxt          = count_r;
    ctl.key            = in_data.operand_value;
    ctl.count          = count_r;
    ctl.pos            = IDX_W'(in_data.target_position);
    ctl.wr_kind        = WR_NONE;
    case (req_type_t'(in_data.req_type))
      REQ_SORTED:               ctl.hit_sel = HIT_ORDER;
      REQ_SEARCH, REQ_FRONT:    ctl.hit_sel = HIT_MATCH;
      default:                  ctl.hit_sel = HIT_POS;
    endcase

    case (req_type_t'(in_data.req_type))
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      REQ_APPEND: begin
        ctl.pos = IDX_W'(count_r);
        if (full) begin
          res.status = ST_FULL;
        end else begin
          ctl.wr_kind        = WR_INSERT;
          res.found_position = 4'(count_r);
          count_nxt          = count_r + 1'b1;
        end
      end
      REQ_INSERT_AT: begin
        if (pos_w > cnt_w) begin
          res.status = ST_BAD_POS;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          ctl.wr_kind        = WR_INSERT;
          res.found_position = 4'(in_data.target_position);
          count_nxt          = count_r + 1'b1;
        end
      end
      REQ_SORTED: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          ctl.wr_kind        = WR_INSERT;
          res.found_position = 4'(chain_pos);
          count_nxt          = count_r + 1'b1;
        end
      end
      REQ_SEARCH, REQ_FRONT: begin
        if (!found_any) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.found_position = 4'(chain_pos);
          if (req_type_t'(in_data.req_type) == REQ_FRONT) begin
            ctl.wr_kind = WR_FRONT;
          end
        end
      end
      REQ_READ: begin
        if (pos_w >= cnt_w) begin
          res.status = ST_BAD_POS;
        end else begin
          res.read_value = val_c[rd_idx];
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase

    if (!accept) begin
      ctl.wr_kind = WR_NONE;
      count_nxt   = count_r;
    end
    res.entry_count = 5'(count_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STORE_DEPTH))
    else $error("count beyond store depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count changed without a transfer");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.req_type == REQ_CLEAR) |=> (out_data_r.entry_count == '0))
    else $error("clear did not empty the store");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |->
      (out_data_r.found_position == '0) && (out_data_r.read_value == '0))
    else $error("failed request reports nonzero position or data");

endmodule

/* tb/tb_sorted_sequence_store.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sorted_sequence_store: directed and random requests, each
// result checked against an in-bench model of the ordered store.
// Depends on sss_pkg and the sorted_sequence_store RTL.
module tb_sorted_sequence_store;
  import sss_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sss_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sss_out_t out_data;

  sorted_sequence_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // model of the store contents
  logic signed [31:0] shadow_entries [STORE_DEPTH];
  int unsigned        shadow_count = 0;

  sss_in_t  request_q [$];
  sss_out_t results_due [$];

  bit          in_took = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;

  function automatic void place_entry(input int unsigned at, input logic signed [31:0] v);
    int unsigned k;
    for (k = shadow_count; k > at; k--) shadow_entries[k] = shadow_entries[k - 1];
    shadow_entries[at] = v;
    shadow_count++;
  endfunction

  function automatic sss_out_t apply_request(input sss_in_t rq);
    sss_out_t           r;
    int unsigned        at;
    int unsigned        k;
    logic signed [31:0] hit;
    r = '0;
    case (req_type_t'(rq.req_type))
      REQ_CLEAR: shadow_count = 0;
      REQ_APPEND: begin
        if (shadow_count >= STORE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.found_position = shadow_count[3:0];
          place_entry(shadow_count, rq.operand_value);
        end
      end
      REQ_INSERT_AT: begin
        // position check takes priority over the full check
        if (rq.target_position > shadow_count) begin
          r.status = ST_BAD_POS;
        end else if (shadow_count >= STORE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.found_position = rq.target_position[3:0];
          place_entry(rq.target_position, rq.operand_value);
        end
      end
      REQ_SORTED: begin
        if (shadow_count >= STORE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at = 0;
          while (at < shadow_count &&
                 $signed(shadow_entries[at]) < $signed(rq.operand_value)) at++;
          r.found_position = at[3:0];
          place_entry(at, rq.operand_value);
        end
      end
      REQ_SEARCH, REQ_FRONT: begin
        at = 0;
        while (at < shadow_count && shadow_entries[at] != rq.operand_value) at++;
        if (at >= shadow_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found_position = at[3:0];
          if (req_type_t'(rq.req_type) == REQ_FRONT && at > 0) begin
            hit = shadow_entries[at];
            for (k = at; k > 0; k--) shadow_entries[k] = shadow_entries[k - 1];
            shadow_entries[0] = hit;
          end
        end
      end
      REQ_READ: begin
        if (rq.target_position >= shadow_count) r.status = ST_BAD_POS;
        else r.read_value = shadow_entries[rq.target_position];
      end
      default: ;
    endcase
    r.entry_count = shadow_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_request(input req_type_t op, input logic signed [31:0] v,
                               input logic [4:0] p);
    sss_in_t rq;
    rq.req_type        = op;
    rq.operand_value   = v;
    rq.target_position = p;
    request_q.push_back(rq);
  endtask

  function automatic sss_in_t random_request();
    sss_in_t     rq;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4)       rq.req_type = REQ_CLEAR;
    else if (pick < 22) rq.req_type = REQ_APPEND;
    else if (pick < 34) rq.req_type = REQ_INSERT_AT;
    else if (pick < 52) rq.req_type = REQ_SORTED;
    else if (pick < 68) rq.req_type = REQ_SEARCH;
    else if (pick < 80) rq.req_type = REQ_FRONT;
    else if (pick < 97) rq.req_type = REQ_READ;
    else                rq.req_type = REQ_NOP;
    // a small value pool keeps duplicates and search hits common
    pick = $urandom_range(99);
    if (pick < 65) begin
      rq.operand_value = $signed($urandom_range(9)) - 4;
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: rq.operand_value = 32'sh8000_0000;
        1: rq.operand_value = 32'sh7fff_ffff;
        2: rq.operand_value = 32'sd0;
        default: rq.operand_value = -32'sd1;
      endcase
    end else begin
      rq.operand_value = $urandom();
    end
    rq.target_position = 5'($urandom_range(16));
    return rq;
  endfunction

  // input side: hold a stalled transfer, otherwise offer the next request or idle
  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random stalls, or one long hold-off on request
  always @(negedge clk) begin : receiver
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_req) begin
      out_stall     <= 1'b1;
      hold_left     <= 60;
      long_hold_req <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    sss_out_t want;
    in_took = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_took) results_due.push_back(apply_request(in_data));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("unrequested result", out_data[31:0], '0);
        end else begin
          want = results_due.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.found_position !== want.found_position)
            report_mismatch("found_position", 32'(out_data.found_position),
                            32'(want.found_position));
          if (out_data.read_value !== want.read_value)
            report_mismatch("read_value", out_data.read_value, want.read_value);
          if (out_data.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(out_data.entry_count),
                            32'(want.entry_count));
        end
      end
    end
  end

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 45;
    // empty store corner cases
    queue_request(REQ_READ, 32'sd0, 5'd0);
    queue_request(REQ_FRONT, 32'sd5, 5'd0);
    queue_request(REQ_SORTED, 32'sd0, 5'd0);
    queue_request(REQ_SORTED, 32'sh8000_0000, 5'd0);
    queue_request(REQ_SORTED, 32'sh7fff_ffff, 5'd0);
    queue_request(REQ_SORTED, -32'sd1, 5'd0);
    queue_request(REQ_APPEND, 32'sd7, 5'd0);
    queue_request(REQ_INSERT_AT, 32'sd7, 5'd0);
    queue_request(REQ_INSERT_AT, 32'sd42, 5'd6);
    queue_request(REQ_INSERT_AT, 32'sd9, 5'd16);
    queue_request(REQ_SEARCH, 32'sd7, 5'd0);
    queue_request(REQ_FRONT, 32'sh7fff_ffff, 5'd0);
    queue_request(REQ_FRONT, 32'sh7fff_ffff, 5'd0);
    queue_request(REQ_READ, 32'sd0, 5'd16);
    queue_request(REQ_NOP, 32'shffff_ffff, 5'd31);
    for (i = 0; i < 9; i++) queue_request(REQ_APPEND, $urandom(), 5'd0);
    // store is full now
    queue_request(REQ_APPEND, 32'sd1, 5'd0);
    queue_request(REQ_INSERT_AT, 32'sd1, 5'd16);
    queue_request(REQ_SORTED, 32'sd1, 5'd0);
    queue_request(REQ_READ, 32'sd0, 5'd15);
    queue_request(REQ_CLEAR, 32'sd0, 5'd0);
    for (i = 0; i < 700; i++) request_q.push_back(random_request());
    long_hold_req = 1'b1;
    wait_drained();

    send_idle_pct = 45;
    recv_idle_pct = 32;
    for (i = 0; i < 650; i++) request_q.push_back(random_request());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < 650; i++) request_q.push_back(random_request());
    wait_drained();

    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
